@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/bfdh_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdh_pkg
// types, constants and hash helpers of the bloom filter core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfdh_pkg;

  localparam int FILTER_BITS = 1048576;
  localparam int KEY_BYTES   = 64;
  localparam int KEY_WORDS   = KEY_BYTES / 4;
  localparam int MAX_HASHES  = 32;

  localparam int M_W     = 21;
  localparam int K_W     = 6;
  localparam int SEED_W  = 10;
  localparam int CFG_W   = 21;
  localparam int IDX_W   = $clog2(FILTER_BITS);
  localparam int ROW_W   = 32;
  localparam int ROW_B   = $clog2(ROW_W);
  localparam int ROWS    = FILTER_BITS / ROW_W;
  localparam int ROW_A_W = IDX_W - ROW_B;
  localparam int WC_W    = $clog2(KEY_WORDS);

  localparam logic [31:0] C1       = 32'hcc9e2d51;
  localparam logic [31:0] C2       = 32'h1b873593;
  localparam logic [31:0] C3       = 32'h85ebca6b;
  localparam logic [31:0] C4       = 32'hc2b2ae35;
  localparam logic [31:0] MIX_ADD  = 32'he6546b64;
  localparam logic [31:0] HASH_LEN = 32'(KEY_WORDS * 4);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [1:0] REG_BITS_IN_USE = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT  = 2'd1;
  localparam logic [1:0] REG_SEED_A      = 2'd2;
  localparam logic [1:0] REG_SEED_B      = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] ha;
    logic [31:0] hb;
  } bfdh_entry_t;

  typedef struct packed {
    logic [M_W-1:0] m;
    logic [K_W-1:0] k;
  } bfdh_cfg_t;

  typedef enum logic [2:0] {
    F_IDLE, F_K1, F_K2, F_MIX, F_FIN1, F_FIN2, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_STEP, B_PROBE, B_RMW, B_DONE
  } back_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] x;
    x = rotl(h ^ k, 13);
    mix_word = (x << 2) + x + MIX_ADD;
  endfunction

  function automatic logic [31:0] fold16(input logic [31:0] h);
    fold16 = h ^ (h >> 16);
  endfunction

endpackage

@@ hw/rtl/bfdh_ram.sv @@
// ----------------------------------------------------------------------------
// bfdh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bfdh_mod.sv @@
// ----------------------------------------------------------------------------
// bfdh_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfdh_mod (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            dividend,
  input  logic [bfdh_pkg::M_W-1:0] divisor,
  output logic                   done,
  output logic [bfdh_pkg::M_W-1:0] rem
);
  import bfdh_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [M_W:0] trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd <= dvd << 1;
        if (trial >= {1'b0, divisor}) begin
          rem <= M_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[M_W-1:0];
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/bfdh_queue.sv @@
// ----------------------------------------------------------------------------
// bfdh_queue
// two entry queue of hashed keys between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfdh_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bfdh_pkg::bfdh_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output bfdh_pkg::bfdh_entry_t head,
  output logic                  not_empty
);
  import bfdh_pkg::*;

  bfdh_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && not_empty);
    end
  end

endmodule

@@ hw/rtl/bfdh_front.sv @@
// ----------------------------------------------------------------------------
// bfdh_front
// takes key words and runs both murmur3 hashes, then queues the key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfdh_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hold,
  input  logic [bfdh_pkg::SEED_W-1:0] seed_a,
  input  logic [bfdh_pkg::SEED_W-1:0] seed_b,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,
  input  logic                      s_tuser,
  output logic                      push,
  output bfdh_pkg::bfdh_entry_t     push_data,
  input  logic                      q_full
);
  import bfdh_pkg::*;

  front_state_t state;
  front_state_t state_next;
  logic [WC_W-1:0] wcnt;
  logic [31:0]     word;
  logic [31:0]     kmix;
  logic [31:0]     ha;
  logic [31:0]     hb;
  logic            cmd;
  logic            last_word;

  assign last_word = (wcnt == WC_W'(KEY_WORDS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (s_tvalid && s_tready) state_next = F_K1;
      F_K1:   state_next = F_K2;
      F_K2:   state_next = F_MIX;
      F_MIX:  state_next = last_word ? F_FIN1 : F_IDLE;
      F_FIN1: state_next = F_FIN2;
      F_FIN2: state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == F_IDLE) && !hold;
    push      = (state == F_PUSH) && !q_full;
    push_data = '{cmd: cmd, ha: fold16(ha), hb: fold16(hb)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      wcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == F_MIX) begin
        wcnt <= last_word ? '0 : wcnt + WC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (s_tvalid && s_tready) begin
          word <= s_tdata;
          if (wcnt == '0) begin
            cmd <= s_tuser;
            ha  <= 32'(seed_a);
            hb  <= 32'(seed_b);
          end
        end
      end
      F_K1:  kmix <= word * C1;
      F_K2:  kmix <= rotl(kmix, 15) * C2;
      F_MIX: begin
        ha <= mix_word(ha, kmix);
        hb <= mix_word(hb, kmix);
      end
      F_FIN1: begin
        ha <= fold16(ha ^ HASH_LEN) * C3;
        hb <= fold16(hb ^ HASH_LEN) * C3;
      end
      F_FIN2: begin
        ha <= (ha ^ (ha >> 13)) * C4;
        hb <= (hb ^ (hb >> 13)) * C4;
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/bfdh_back.sv @@
// ----------------------------------------------------------------------------
// bfdh_back
// clears the filter store, then probes it for each queued key
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfdh_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bfdh_pkg::bfdh_cfg_t   cfg,
  output logic                  clearing,
  input  bfdh_pkg::bfdh_entry_t head,
  input  logic                  q_not_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_query,
  output logic                  out_present
);
  import bfdh_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [ROW_A_W-1:0] clr_addr;
  logic               cmd;
  logic [31:0]        ha;
  logic [31:0]        acc;
  logic [M_W-1:0]     step;
  logic [K_W-1:0]     probe;
  logic [IDX_W-1:0]   idx;
  logic               all_set;
  logic               last_probe;
  logic               hit;
  logic               out_load;

  logic               mod_start;
  logic [31:0]        mod_dvd;
  logic               mod_done;
  logic [M_W-1:0]     mod_rem;

  logic               ram_we;
  logic [ROW_A_W-1:0] ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [ROW_A_W-1:0] ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;

  assign last_probe = (probe + K_W'(1) == cfg.k);
  assign hit        = ram_rdata[idx[ROW_B-1:0]];

  bfdh_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (cfg.m),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bfdh_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == ROW_A_W'(ROWS - 1)) state_next = B_IDLE;
      B_IDLE:  if (q_not_empty) state_next = B_STEP;
      B_STEP:  if (mod_done) state_next = B_PROBE;
      B_PROBE: if (mod_done) state_next = B_RMW;
      B_RMW: begin
        if ((cmd == CMD_QUERY && !hit) || last_probe) state_next = B_DONE;
        else state_next = B_PROBE;
      end
      B_DONE:  if (!out_valid || out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing  = (state == B_CLEAR);
    pop       = (state == B_IDLE) && q_not_empty;
    out_load  = (state == B_DONE) && (!out_valid || out_ready);
    mod_start = 1'b0;
    mod_dvd   = acc + 32'(step);
    unique case (state)
      B_IDLE: begin
        mod_start = q_not_empty;
        mod_dvd   = head.hb;
      end
      B_STEP: begin
        mod_start = mod_done;
        mod_dvd   = ha;
      end
      B_RMW: mod_start = !((cmd == CMD_QUERY && !hit) || last_probe);
      default: ;
    endcase
    ram_raddr = mod_rem[IDX_W-1:ROW_B];
    ram_we    = clearing || (state == B_RMW && cmd == CMD_INSERT);
    ram_waddr = clearing ? clr_addr : idx[IDX_W-1:ROW_B];
    ram_wdata = clearing ? '0 : (ram_rdata | (ROW_W'(1) << idx[ROW_B-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ROW_A_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        cmd <= head.cmd;
        ha  <= head.ha;
      end
      B_STEP: begin
        if (mod_done) begin
          step    <= mod_rem;
          acc     <= ha;
          probe   <= '0;
          all_set <= 1'b1;
        end
      end
      B_PROBE: if (mod_done) idx <= mod_rem[IDX_W-1:0];
      B_RMW: begin
        if (cmd == CMD_QUERY && !hit) all_set <= 1'b0;
        acc   <= acc + 32'(step);
        probe <= probe + K_W'(1);
      end
      B_DONE: begin
        if (out_load) begin
          out_query   <= cmd;
          out_present <= (cmd == CMD_QUERY) && all_set;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/bloom_filter_double_hash_core.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_core
// bloom filter over a 1M bit store with two murmur3 hashes and double hashing
// ----------------------------------------------------------------------------
// input words: s_tdata carries one 32-bit key word, s_tuser the command
// (0 insert, 1 query), read on the first of the 16 words of a key.
// output words: one per key, m_tuser says query, m_tdata bit 0 is present.
// configuration: cfg_wen/cfg_index/cfg_data, write only while idle.
// each key word passes the hash front (two multiplies and a mix) before the
// next word is taken, and the last word of a key adds finalization and push.
// the probe side then pops, runs the step modulo and, per probe, a bit serial
// remainder and a memory read-modify-write, then loads the output; a query
// ends at its first clear bit. a two entry queue lets the next key hash while
// probing goes on.
// after reset the store is cleared one 32-bit row per cycle, all 32768 rows,
// and s_tready stays low until then.
// a stalled output holds its word; the probe side waits with its result and
// the front keeps hashing until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bloom_filter_double_hash_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [31:0]              s_tdata,  // key_word
  input  logic                     s_tuser,  // command
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,  // present, zero pad
  output logic                     m_tuser,  // was_query
  input  logic                     cfg_wen,
  input  logic [1:0]               cfg_index,
  input  logic [bfdh_pkg::CFG_W-1:0] cfg_data
);
  import bfdh_pkg::*;

  bfdh_cfg_t          cfg;
  logic [SEED_W-1:0]  seed_a;
  logic [SEED_W-1:0]  seed_b;
  logic               clearing;
  logic               push;
  bfdh_entry_t        push_data;
  logic               q_full;
  logic               pop;
  bfdh_entry_t        head;
  logic               q_not_empty;
  logic               present;
  logic [M_W-1:0]     m_wr;
  logic [K_W-1:0]     k_wr;

  assign m_wr = cfg_data[M_W-1:0];
  assign k_wr = cfg_data[K_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m  <= M_W'(FILTER_BITS);
      cfg.k  <= K_W'(5);
      seed_a <= '0;
      seed_b <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BITS_IN_USE: begin
          if (m_wr < M_W'(2)) cfg.m <= M_W'(2);
          else if (m_wr > M_W'(FILTER_BITS)) cfg.m <= M_W'(FILTER_BITS);
          else cfg.m <= m_wr;
        end
        REG_HASH_COUNT: begin
          if (k_wr == '0) cfg.k <= K_W'(1);
          else if (k_wr > K_W'(MAX_HASHES)) cfg.k <= K_W'(MAX_HASHES);
          else cfg.k <= k_wr;
        end
        REG_SEED_A: seed_a <= cfg_data[SEED_W-1:0];
        REG_SEED_B: seed_b <= cfg_data[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  bfdh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .seed_a    (seed_a),
    .seed_b    (seed_b),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  bfdh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty)
  );

  bfdh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clearing    (clearing),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_query   (m_tuser),
    .out_present (present)
  );

  assign m_tdata = {7'b0, present};

endmodule

@@ hw/rtl/bfdh_checker.sv @@
// ----------------------------------------------------------------------------
// bfdh_checker
// port level checks of the bloom filter core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfdh_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  `BF_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
  `BF_ASSERT(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled output changed")
  `BF_ASSERT(a_insert_absent, clk, rst, m_tvalid && !m_tuser |-> m_tdata == 8'd0, "insert reported present")
  `BF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !s_tready && !m_tvalid, "busy after reset")

endmodule

bind bloom_filter_double_hash_core bfdh_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the bloom filter core with double murmur3 hashing
// ----------------------------------------------------------------------------
// keys stream in as 16-word frames and are hashed by a local model of the
// filter. Each result word is checked against the oldest pending answer.
// The run covers config extremes and saturation, insert/query runs over a
// pool of known keys, random idling on both sides and long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bfdh_pkg::*;

  localparam int WATCHDOG = 200000;

  typedef struct {
    logic was_query;
    logic present;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata = '0;   // key_word
  logic             s_tuser = 1'b0; // command
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;        // present, zero pad
  logic             m_tuser;        // was_query
  logic             cfg_wen = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bloom_filter_double_hash_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter model
  bit          filter_store [FILTER_BITS];
  logic [31:0] run_a, run_b;
  int          word_pos;
  logic        key_cmd;
  int unsigned m_used, k_used;
  logic [9:0]  seed_a_q, seed_b_q;

  answer_t      answers[$];
  logic [511:0] key_pool[$];
  int           errors, keys_sent, results_seen, idle_cycles;
  int           send_idle_pct, recv_stall_pct;
  bit           hold_off_req;

  function automatic logic [31:0] rot(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur_mix(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] t;
    t = rot(w * C1, 15) * C2;
    return rot(h ^ t, 13) * 32'd5 + MIX_ADD;
  endfunction

  function automatic logic [31:0] murmur_fin(input logic [31:0] h);
    h ^= 32'(KEY_WORDS * 4);
    h ^= h >> 16;
    h *= C3;
    h ^= h >> 13;
    h *= C4;
    h ^= h >> 16;
    return h;
  endfunction

  task automatic absorb_word(input logic cmd, input logic [31:0] w);
    logic [31:0] ha, hb, stride, pos;
    answer_t     ans;
    bit          all_set;
    if (word_pos == 0) begin
      key_cmd = cmd;
      run_a = 32'(seed_a_q);
      run_b = 32'(seed_b_q);
    end
    run_a = murmur_mix(run_a, w);
    run_b = murmur_mix(run_b, w);
    if (word_pos < KEY_WORDS - 1) begin
      word_pos++;
    end else begin
      word_pos = 0;
      ha = murmur_fin(run_a);
      hb = murmur_fin(run_b);
      stride = hb % m_used;
      all_set = 1'b1;
      for (int i = 0; i < k_used; i++) begin
        pos = (ha + 32'(i) * stride) % m_used;
        if (key_cmd == CMD_INSERT) filter_store[pos] = 1'b1;
        else if (!filter_store[pos]) all_set = 1'b0;
      end
      ans.was_query = key_cmd;
      ans.present = (key_cmd == CMD_QUERY) && all_set;
      answers.push_back(ans);
    end
  endtask

  task automatic send_word(input logic cmd, input logic [31:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    absorb_word(cmd, w);
  endtask

  task automatic send_key(input logic cmd, input logic [511:0] key);
    for (int j = 0; j < KEY_WORDS; j++)
      send_word(j == 0 ? cmd : logic'($urandom_range(1)), key[32*j +: 32]);
    keys_sent++;
    if (cmd == CMD_INSERT) key_pool.push_back(key);
  endtask

  function automatic logic [511:0] rand_key();
    logic [511:0] key;
    for (int j = 0; j < KEY_WORDS; j++) key[32*j +: 32] = $urandom;
    return key;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    int unsigned mv;
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_BITS_IN_USE: begin
        mv = val & 32'h1fffff;
        m_used = (mv < 2) ? 2 : (mv > FILTER_BITS) ? FILTER_BITS : mv;
      end
      REG_HASH_COUNT: begin
        k_used = val & 6'h3f;
        k_used = (k_used < 1) ? 1 : (k_used > MAX_HASHES) ? MAX_HASHES : k_used;
      end
      REG_SEED_A: seed_a_q = val[9:0];
      REG_SEED_B: seed_b_q = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned m, k, sa, sb);
    cfg_write(REG_BITS_IN_USE, m);
    cfg_write(REG_HASH_COUNT, k);
    cfg_write(REG_SEED_A, sa);
    cfg_write(REG_SEED_B, sb);
  endtask

  // mostly inserts and queries of known keys, some fresh queries
  task automatic run_keys(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45 || key_pool.size() == 0) send_key(CMD_INSERT, rand_key());
      else if (r < 85) send_key(CMD_QUERY, key_pool[$urandom_range(key_pool.size() - 1)]);
      else send_key(CMD_QUERY, rand_key());
    end
  endtask

  task automatic test_directed();
    send_key(CMD_INSERT, '0);
    send_key(CMD_QUERY, '0);
    send_key(CMD_QUERY, '1);
    send_key(CMD_INSERT, '1);
    send_key(CMD_QUERY, '1);
    drain();
    // smallest filter, single probe
    set_config(0, 0, 1023, 1023);
    send_key(CMD_QUERY, rand_key());
    send_key(CMD_INSERT, rand_key());
    send_key(CMD_QUERY, rand_key());
    drain();
    // saturation of oversized values, most probes
    set_config(2097151, 63, 0, 999);
    send_key(CMD_INSERT, '0);
    send_key(CMD_QUERY, '0);
    drain();
    set_config(1, 33, 512, 1);
    send_key(CMD_QUERY, '1);
    drain();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;
    set_config(FILTER_BITS, 5, 0, 0);
    run_keys(25);
    drain();
    send_idle_pct = 49; recv_stall_pct = 0;
    set_config(64, 3, $urandom_range(1023), $urandom_range(1023));
    run_keys(25);
    drain();
    send_idle_pct = 0;  recv_stall_pct = 49;
    set_config($urandom_range(2, 5000), $urandom_range(1, 8),
               $urandom_range(1023), $urandom_range(1023));
    run_keys(25);
    drain();
    send_idle_pct = 10; recv_stall_pct = 10;
    set_config(1000, 32, 999, 0);
    run_keys(8);
    drain();
    set_config($urandom_range(2, 2097151), $urandom_range(0, 63),
               $urandom_range(1023), $urandom_range(1023));
    run_keys(15);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    set_config(4096, 2, 7, 11);
    hold_off_req = 1'b1;
    run_keys(6);
    // sender pauses until every answer has come back
    drain();
    run_keys(6);
    drain();
  endtask

  int hold_count;
  always @(posedge clk) begin
    if (hold_off_req) begin
      m_tready <= 1'b0;
      hold_count++;
      if (hold_count >= 3000) begin
        hold_off_req = 1'b0;
        hold_count = 0;
      end
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (answers.size() == 0) begin
          $error("result word with no answer pending");
          errors++;
        end else begin
          e = answers.pop_front();
          if (m_tuser !== e.was_query) begin
            $error("was_query expected %0b actual %0b", e.was_query, m_tuser);
            errors++;
          end
          if (m_tdata[0] !== e.present) begin
            $error("present expected %0b actual %0b", e.present, m_tdata[0]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    word_pos = 0; run_a = '0; run_b = '0; key_cmd = CMD_INSERT;
    m_used = FILTER_BITS; k_used = 5; seed_a_q = '0; seed_b_q = '0;
    errors = 0; keys_sent = 0; results_seen = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off_req = 1'b0; hold_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    $display("covered %0d keys, %0d result words, config extremes and saturation,",
             keys_sent, results_seen);
    $display("idle and stall phases, a long output hold-off and a drained pause");
    if (errors == 0 && answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
